@@ hw/rtl/eno2pl_pkg.sv @@
// Shared types, constants and helpers for the ENO2 positivity-limited reconstruction unit.
// No dependencies; every other file of the block imports this package.
package eno2pl_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int MAX_POINTS = 4;
    localparam int NUM_PREG   = 4;
    localparam int NP_EFF     = (MAX_POINTS < NUM_PREG) ? MAX_POINTS : NUM_PREG;
    localparam int IDX_W      = $clog2(NUM_PREG);
    localparam int VW         = 32;
    localparam int HW         = 31;
    localparam int PW         = 17;
    localparam int EW         = 16;
    localparam int NPW        = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DW     = 17;
    localparam int DIV_W      = 35;
    localparam int NUM_VALS   = 9;
    localparam int NUM_RES    = 6;
    localparam int VAL_BASE   = 3 * HW;
    localparam int S_TDATA_W  = ((VAL_BASE + NUM_VALS * VW + 7) / 8) * 8;
    localparam int M_TDATA_W  = NUM_RES * VW;

    localparam logic signed [VW-1:0] ONE_Q  = VW'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [PW:0]   HALF_Q = (PW+1)'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [VW-1:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [VW-1:0] S32_MIN = 32'sh8000_0000;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_0    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_1    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_2    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_3    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EPS_FLOOR  = 3'd5;

    localparam logic [1:0] QTY_RHO = 2'd0;
    localparam logic [1:0] QTY_VEL = 2'd1;
    localparam logic [1:0] QTY_EN  = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_OFF,
        OP_SLOPE_DIV1,
        OP_SLOPE_DIV2,
        OP_K1_SAVE,
        OP_K_PICK,
        OP_MUL_KOFF,
        OP_RHO_DEV,
        OP_DIV_THR,
        OP_THR_MIN,
        OP_MUL_VV,
        OP_EC,
        OP_VP,
        OP_ACC,
        OP_MUL_VPVP,
        OP_EP,
        OP_DIV_THE,
        OP_THE_MIN,
        OP_MUL_LK,
        OP_MUL_TOFF,
        OP_RES,
        OP_PUBLISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t           op;
        logic [1:0]       qty;
        logic [IDX_W-1:0] idx;
        logic             face;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic skip;
        logic low;
    } dp_status_t;

    function automatic logic signed [VW-1:0] sat32(input logic signed [DIV_W-1:0] x);
        logic [DIV_W-VW:0] top;
        top = x[DIV_W-1:VW-1];
        if ((&top) || !(|top))
            return x[VW-1:0];
        else
            return x[DIV_W-1] ? S32_MIN : S32_MAX;
    endfunction

endpackage

@@ hw/rtl/eno2pl_div.sv @@
// Shared iterative divider: (num << FRAC_BITS) / den, one quotient bit per cycle,
// truncated and saturated to signed 32 bits. Depends on eno2pl_pkg.
module eno2pl_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [eno2pl_pkg::DIV_W-1:0] num,
    input  logic signed [eno2pl_pkg::DIV_W-1:0] den,
    output logic                                done,
    output logic signed [eno2pl_pkg::VW-1:0]    quo
);
    import eno2pl_pkg::*;

    localparam int MW    = DIV_W;
    localparam int DVD_W = MW + FRAC_BITS;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [MW-1:0]     rem_reg;
    logic [DVD_W-1:0]  quo_reg;
    logic [MW-1:0]     den_reg;
    logic              neg_reg;

    logic [MW-1:0]     num_mag;
    logic [MW-1:0]     den_mag;
    logic [MW:0]       trial;
    logic [MW:0]       diff;
    logic              ge;
    logic              big;

    assign num_mag = num[DIV_W-1] ? MW'(-num) : MW'(num);
    assign den_mag = den[DIV_W-1] ? MW'(-den) : MW'(den);
    assign trial   = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff    = trial - {1'b0, den_reg};
    assign ge      = (trial >= {1'b0, den_reg});
    assign big     = |quo_reg[DVD_W-1:VW-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                if (den_mag == '0) begin
                    neg_reg  <= num[DIV_W-1];
                    quo_reg  <= '1;
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    neg_reg  <= num[DIV_W-1] ^ den[DIV_W-1];
                    dvd_reg  <= {num_mag, {FRAC_BITS{1'b0}}};
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                    den_reg  <= den_mag;
                    cnt_reg  <= '0;
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                rem_reg <= ge ? diff[MW-1:0] : trial[MW-1:0];
                quo_reg <= {quo_reg[DVD_W-2:0], ge};
                dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (neg_reg)
            quo = big ? S32_MIN : VW'(-quo_reg[VW-1:0]);
        else
            quo = big ? S32_MAX : quo_reg[VW-1:0];
    end

    assign done = done_reg;

    a_done_after_start: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> !busy_reg || !done_reg)
        else $error("divider done while busy");

endmodule

@@ hw/rtl/eno2pl_dp.sv @@
// Datapath: stencil registers, shared fixed-point multiplier, limiter registers, outputs.
// Executes one command per cycle from the controller. Depends on eno2pl_pkg, eno2pl_div.
module eno2pl_dp (
    input  logic                                             aclk,
    input  eno2pl_pkg::dp_cmd_t                              cmd,
    input  logic [eno2pl_pkg::S_TDATA_W-1:0]                 s_tdata,
    input  logic [eno2pl_pkg::NUM_PREG-1:0][eno2pl_pkg::PW-1:0] pts,
    input  logic [eno2pl_pkg::EW-1:0]                        eps,
    output eno2pl_pkg::dp_status_t                           status,
    output logic [eno2pl_pkg::M_TDATA_W-1:0]                 m_data,
    input  logic                                             div_aresetn
);
    import eno2pl_pkg::*;

    localparam int SW = DIV_W;

    logic [HW-1:0]          h2_reg;
    logic [VW-1:0]          hl_reg, hr_reg;
    logic signed [VW-1:0]   ua_reg [3];
    logic signed [VW-1:0]   um_reg [3];
    logic signed [VW-1:0]   ub_reg [3];
    logic signed [VW-1:0]   off_reg [NUM_PREG];
    logic signed [VW-1:0]   ep_reg [NUM_PREG];
    logic signed [VW-1:0]   k_reg [3];
    logic signed [VW-1:0]   k1_reg, thr_reg, the_reg, ec_reg, vp_reg, tk_reg, mul_reg;
    logic signed [SW-1:0]   acc_reg;
    logic [VW:0]            dev_reg;
    logic                   low_reg;
    logic signed [VW-1:0]   res_reg [NUM_RES];
    logic [M_TDATA_W-1:0]   out_reg;

    logic signed [VW:0]     ma_op, mb_op;
    logic [VW-1:0]          ma_mag, mb_mag;
    logic [2*VW-1:0]        prod, psh;
    logic                   pneg, pbig;
    logic signed [VW-1:0]   fres;
    logic signed [PW:0]     pts_off;

    logic signed [SW-1:0]   num_op, den_op;
    logic                   div_start;
    logic                   div_done;
    logic signed [VW-1:0]   div_q;

    logic signed [SW-1:0]   hl_w, hr_w, eps_w, thr_diff, the_den;
    logic signed [VW-1:0]   eps_s;
    logic signed [VW-1:0]   lim;
    logic signed [SW-1:0]   sum_mid;
    logic signed [VW-1:0]   sum_sat;
    logic signed [SW-1:0]   devd;
    logic [VW+3:0]          dev10;
    logic [VW:0]            k1_mag, kq_mag;
    logic signed [VW-1:0]   ep_new, ec_new;
    logic [2:0]             res_idx;

    assign hl_w   = SW'({1'b0, hl_reg});
    assign hr_w   = SW'({1'b0, hr_reg});
    assign eps_s  = VW'({1'b0, eps});
    assign eps_w  = SW'(eps_s);
    assign pts_off = $signed({1'b0, pts[cmd.idx]}) - HALF_Q;

    always_comb begin
        case (cmd.qty)
            QTY_RHO: lim = thr_reg;
            QTY_EN:  lim = the_reg;
            default: lim = ONE_Q;
        endcase
    end

    always_comb begin
        ma_op = '0;
        mb_op = '0;
        case (cmd.op)
            OP_OFF: begin
                ma_op = (VW+1)'({2'b00, h2_reg});
                mb_op = (VW+1)'(pts_off);
            end
            OP_MUL_KOFF: begin
                ma_op = (VW+1)'(k_reg[cmd.qty]);
                mb_op = (VW+1)'(off_reg[cmd.idx]);
            end
            OP_MUL_VV: begin
                ma_op = (VW+1)'(um_reg[QTY_VEL]);
                mb_op = (VW+1)'(um_reg[QTY_VEL]);
            end
            OP_MUL_VPVP: begin
                ma_op = (VW+1)'(vp_reg);
                mb_op = (VW+1)'(vp_reg);
            end
            OP_MUL_LK: begin
                ma_op = (VW+1)'(lim);
                mb_op = (VW+1)'(k_reg[cmd.qty]);
            end
            OP_MUL_TOFF: begin
                ma_op = (VW+1)'(tk_reg);
                mb_op = (VW+1)'(off_reg[cmd.idx]);
            end
            default: begin
                ma_op = '0;
                mb_op = '0;
            end
        endcase
    end

    assign ma_mag = ma_op[VW] ? VW'(-ma_op) : VW'(ma_op);
    assign mb_mag = mb_op[VW] ? VW'(-mb_op) : VW'(mb_op);
    assign prod   = (2*VW)'(ma_mag) * (2*VW)'(mb_mag);
    assign psh    = prod >> FRAC_BITS;
    assign pneg   = ma_op[VW] ^ mb_op[VW];
    assign pbig   = |psh[2*VW-1:VW-1];
    assign fres   = pneg ? (pbig ? S32_MIN : VW'(-psh[VW-1:0]))
                         : (pbig ? S32_MAX : psh[VW-1:0]);

    assign thr_diff = SW'(um_reg[QTY_RHO]) - eps_w;
    assign the_den  = SW'(ec_reg) - SW'(ep_reg[cmd.idx]);

    always_comb begin
        num_op    = '0;
        den_op    = '0;
        div_start = 1'b0;
        case (cmd.op)
            OP_SLOPE_DIV1: begin
                num_op    = (SW'(um_reg[cmd.qty]) - SW'(ua_reg[cmd.qty])) <<< 1;
                den_op    = hl_w;
                div_start = 1'b1;
            end
            OP_SLOPE_DIV2: begin
                num_op    = (SW'(ub_reg[cmd.qty]) - SW'(um_reg[cmd.qty])) <<< 1;
                den_op    = hr_w;
                div_start = 1'b1;
            end
            OP_DIV_THR: begin
                num_op    = thr_diff[SW-1] ? -thr_diff : thr_diff;
                den_op    = SW'(dev_reg);
                div_start = 1'b1;
            end
            OP_DIV_THE: begin
                num_op    = SW'(ec_reg);
                den_op    = the_den;
                div_start = 1'b1;
            end
            default: begin
                num_op    = '0;
                den_op    = '0;
                div_start = 1'b0;
            end
        endcase
    end

    eno2pl_div u_div (
        .aclk    (aclk),
        .aresetn (div_aresetn),
        .start   (div_start),
        .num     (num_op),
        .den     (den_op),
        .done    (div_done),
        .quo     (div_q)
    );

    assign sum_mid = SW'(mul_reg) + SW'(um_reg[cmd.qty]);
    assign sum_sat = sat32(sum_mid);
    assign devd    = SW'(um_reg[QTY_RHO]) - SW'(sum_sat);
    assign dev10   = (VW+4)'({dev_reg, 3'b000}) + (VW+4)'({dev_reg, 1'b0});
    assign k1_mag  = k1_reg[VW-1] ? (VW+1)'(-(VW+1)'(k1_reg)) : (VW+1)'(k1_reg);
    assign kq_mag  = div_q[VW-1] ? (VW+1)'(-(VW+1)'(div_q)) : (VW+1)'(div_q);
    assign ep_new  = sat32(acc_reg - SW'(mul_reg >>> 1));
    assign ec_new  = sat32(SW'(um_reg[QTY_EN]) - SW'(mul_reg >>> 1));
    assign res_idx = {cmd.qty, cmd.face};

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                h2_reg  <= s_tdata[2*HW-1:HW];
                hl_reg  <= VW'(s_tdata[HW-1:0]) + VW'(s_tdata[2*HW-1:HW]);
                hr_reg  <= VW'(s_tdata[2*HW-1:HW]) + VW'(s_tdata[3*HW-1:2*HW]);
                for (int q = 0; q < 3; q++) begin
                    ua_reg[q] <= s_tdata[VAL_BASE + (3*q)*VW +: VW];
                    um_reg[q] <= s_tdata[VAL_BASE + (3*q+1)*VW +: VW];
                    ub_reg[q] <= s_tdata[VAL_BASE + (3*q+2)*VW +: VW];
                end
                thr_reg <= ONE_Q;
                the_reg <= ONE_Q;
                low_reg <= 1'b0;
            end
            OP_OFF:      off_reg[cmd.idx] <= fres;
            OP_K1_SAVE:  k1_reg <= div_q;
            OP_K_PICK:   k_reg[cmd.qty] <= (k1_mag > kq_mag) ? div_q : k1_reg;
            OP_MUL_KOFF: mul_reg <= fres;
            OP_MUL_VV:   mul_reg <= fres;
            OP_MUL_VPVP: mul_reg <= fres;
            OP_MUL_TOFF: mul_reg <= fres;
            OP_MUL_LK:   tk_reg <= fres;
            OP_RHO_DEV:  dev_reg <= devd[SW-1] ? (VW+1)'(-devd) : (VW+1)'(devd);
            OP_THR_MIN: begin
                if (div_q < thr_reg)
                    thr_reg <= div_q;
            end
            OP_THE_MIN: begin
                if (div_q < the_reg)
                    the_reg <= div_q;
            end
            OP_EC:       ec_reg <= ec_new;
            OP_VP:       vp_reg <= sum_sat;
            OP_ACC:      acc_reg <= SW'(mul_reg) + SW'(um_reg[QTY_EN]);
            OP_EP: begin
                ep_reg[cmd.idx] <= ep_new;
                if (ep_new < eps_s)
                    low_reg <= 1'b1;
            end
            OP_RES:      res_reg[res_idx] <= sum_sat;
            OP_PUBLISH: begin
                for (int r = 0; r < NUM_RES; r++)
                    out_reg[r*VW +: VW] <= res_reg[r];
            end
            default: ;
        endcase
    end

    assign status.div_done = div_done;
    assign status.skip     = (dev10 < (VW+4)'(eps));
    assign status.low      = low_reg;
    assign m_data          = out_reg;

endmodule

@@ hw/rtl/eno2pl_ctrl.sv @@
// Controller: sequences slopes, limiters and face values through the datapath,
// and owns the stream handshakes. Depends on eno2pl_pkg.
module eno2pl_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [eno2pl_pkg::NPW-1:0]        num_points,
    input  eno2pl_pkg::dp_status_t            status,
    output eno2pl_pkg::dp_cmd_t               cmd
);
    import eno2pl_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_OFF, S_DIV1, S_W1, S_K1, S_DIV2, S_W2, S_PICK,
        S_RMUL, S_RDEV, S_RCHK, S_RDIV, S_RW, S_RMIN,
        S_VV, S_EC, S_EMU, S_VP, S_EMK, S_ACC, S_EVV, S_EP, S_LCHK,
        S_TDIV, S_TW, S_TMIN, S_LK, S_TOFF, S_RES, S_DONE
    } state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [1:0]       qty_reg;
    logic             face_reg;
    logic             m_tvalid_reg;
    logic [IDX_W-1:0] n_last;
    logic             out_free;
    logic             idx_end;

    always_comb begin
        if (num_points == '0)
            n_last = '0;
        else if (num_points > NPW'(NP_EFF))
            n_last = IDX_W'(NP_EFF - 1);
        else
            n_last = IDX_W'(num_points - 1'b1);
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign idx_end  = (idx_reg == n_last);
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd.op   = OP_NONE;
        cmd.qty  = qty_reg;
        cmd.idx  = idx_reg;
        cmd.face = face_reg;
        case (state_reg)
            S_IDLE: cmd.op = s_tvalid ? OP_LOAD : OP_NONE;
            S_OFF:  cmd.op = OP_OFF;
            S_DIV1: cmd.op = OP_SLOPE_DIV1;
            S_K1:   cmd.op = OP_K1_SAVE;
            S_DIV2: cmd.op = OP_SLOPE_DIV2;
            S_PICK: cmd.op = OP_K_PICK;
            S_RMUL: begin
                cmd.op  = OP_MUL_KOFF;
                cmd.qty = QTY_RHO;
            end
            S_RDEV: begin
                cmd.op  = OP_RHO_DEV;
                cmd.qty = QTY_RHO;
            end
            S_RDIV: cmd.op = OP_DIV_THR;
            S_RMIN: cmd.op = OP_THR_MIN;
            S_VV:   cmd.op = OP_MUL_VV;
            S_EC:   cmd.op = OP_EC;
            S_EMU: begin
                cmd.op  = OP_MUL_KOFF;
                cmd.qty = QTY_VEL;
            end
            S_VP: begin
                cmd.op  = OP_VP;
                cmd.qty = QTY_VEL;
            end
            S_EMK: begin
                cmd.op  = OP_MUL_KOFF;
                cmd.qty = QTY_EN;
            end
            S_ACC:  cmd.op = OP_ACC;
            S_EVV:  cmd.op = OP_MUL_VPVP;
            S_EP:   cmd.op = OP_EP;
            S_TDIV: cmd.op = OP_DIV_THE;
            S_TMIN: cmd.op = OP_THE_MIN;
            S_LK:   cmd.op = OP_MUL_LK;
            S_TOFF: begin
                cmd.op  = OP_MUL_TOFF;
                cmd.idx = face_reg ? n_last : '0;
            end
            S_RES:  cmd.op = OP_RES;
            S_DONE: cmd.op = out_free ? OP_PUBLISH : OP_NONE;
            default: cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            idx_reg      <= '0;
            qty_reg      <= '0;
            face_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (state_reg == S_DONE && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        idx_reg   <= '0;
                        qty_reg   <= QTY_RHO;
                        face_reg  <= 1'b0;
                        state_reg <= S_OFF;
                    end
                end
                S_OFF: begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == IDX_W'(NUM_PREG - 1))
                        state_reg <= S_DIV1;
                end
                S_DIV1: state_reg <= S_W1;
                S_W1:   if (status.div_done) state_reg <= S_K1;
                S_K1:   state_reg <= S_DIV2;
                S_DIV2: state_reg <= S_W2;
                S_W2:   if (status.div_done) state_reg <= S_PICK;
                S_PICK: begin
                    if (qty_reg == QTY_EN) begin
                        idx_reg   <= '0;
                        state_reg <= S_RMUL;
                    end else begin
                        qty_reg   <= qty_reg + 1'b1;
                        state_reg <= S_DIV1;
                    end
                end
                S_RMUL: state_reg <= S_RDEV;
                S_RDEV: state_reg <= S_RCHK;
                S_RCHK: begin
                    if (!status.skip)
                        state_reg <= S_RDIV;
                    else if (idx_end)
                        state_reg <= S_VV;
                    else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_RMUL;
                    end
                end
                S_RDIV: state_reg <= S_RW;
                S_RW:   if (status.div_done) state_reg <= S_RMIN;
                S_RMIN: begin
                    if (idx_end)
                        state_reg <= S_VV;
                    else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_RMUL;
                    end
                end
                S_VV: state_reg <= S_EC;
                S_EC: begin
                    idx_reg   <= '0;
                    state_reg <= S_EMU;
                end
                S_EMU: state_reg <= S_VP;
                S_VP:  state_reg <= S_EMK;
                S_EMK: state_reg <= S_ACC;
                S_ACC: state_reg <= S_EVV;
                S_EVV: state_reg <= S_EP;
                S_EP: begin
                    if (idx_end)
                        state_reg <= S_LCHK;
                    else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_EMU;
                    end
                end
                S_LCHK: begin
                    idx_reg  <= '0;
                    qty_reg  <= QTY_RHO;
                    face_reg <= 1'b0;
                    state_reg <= status.low ? S_TDIV : S_LK;
                end
                S_TDIV: state_reg <= S_TW;
                S_TW:   if (status.div_done) state_reg <= S_TMIN;
                S_TMIN: begin
                    if (idx_end)
                        state_reg <= S_LK;
                    else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_TDIV;
                    end
                end
                S_LK:   state_reg <= S_TOFF;
                S_TOFF: state_reg <= S_RES;
                S_RES: begin
                    if (!face_reg) begin
                        face_reg  <= 1'b1;
                        state_reg <= S_TOFF;
                    end else begin
                        face_reg <= 1'b0;
                        if (qty_reg == QTY_EN)
                            state_reg <= S_DONE;
                        else begin
                            qty_reg   <= qty_reg + 1'b1;
                            state_reg <= S_LK;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        status.div_done |-> (state_reg == S_W1 || state_reg == S_W2 ||
                             state_reg == S_RW || state_reg == S_TW))
        else $error("divider finished outside a wait state");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transaction taken while busy");

    a_publish_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_PUBLISH) |=> m_tvalid)
        else $error("published result not offered");

    a_point_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EP || state_reg == S_TDIV || state_reg == S_RMUL)
            |-> (idx_reg <= n_last))
        else $error("point index past last point in use");

endmodule

@@ hw/rtl/eno2_positivity_limited_reconstruct_unit.sv @@
// Top level: ENO2 minmod reconstruction with positivity limiter, one stencil per transaction.
// Time from input transaction to m_tvalid is least with one point and no limiting divides and
// most with four points and both limiters dividing, each quotient from the iterative divider.
// One stencil in flight; the next is taken once the previous result is in the output register,
// where it waits and stalls the controller until it drains.
// Reset (aresetn, synchronous, active low) clears control and loads config reset values.
// Depends on eno2pl_pkg, eno2pl_ctrl, eno2pl_dp, eno2pl_div.
module eno2_positivity_limited_reconstruct_unit (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // width_left, width_mid, width_right, rho1..3, vel1..3, en1..3, zero pad
    input  logic [eno2pl_pkg::S_TDATA_W-1:0]       s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // rho_left, rho_right, vel_left, vel_right, en_left, en_right
    output logic [eno2pl_pkg::M_TDATA_W-1:0]       m_tdata,
    input  logic                                   cfg_wr_en,
    input  logic [eno2pl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [eno2pl_pkg::CFG_DW-1:0]          cfg_data
);
    import eno2pl_pkg::*;

    logic [NPW-1:0]                num_points_reg;
    logic [NUM_PREG-1:0][PW-1:0]   pts_reg;
    logic [EW-1:0]                 eps_reg;
    dp_cmd_t                       cmd;
    dp_status_t                    status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_points_reg <= NPW'(2);
            pts_reg[0]     <= PW'(0);
            pts_reg[1]     <= PW'(65536);
            pts_reg[2]     <= PW'(0);
            pts_reg[3]     <= PW'(0);
            eps_reg        <= EW'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_NUM_POINTS: num_points_reg <= cfg_data[NPW-1:0];
                REG_POINT_0:    pts_reg[0]     <= cfg_data[PW-1:0];
                REG_POINT_1:    pts_reg[1]     <= cfg_data[PW-1:0];
                REG_POINT_2:    pts_reg[2]     <= cfg_data[PW-1:0];
                REG_POINT_3:    pts_reg[3]     <= cfg_data[PW-1:0];
                REG_EPS_FLOOR:  eps_reg        <= cfg_data[EW-1:0];
                default: ;
            endcase
        end
    end

    eno2pl_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .num_points (num_points_reg),
        .status     (status),
        .cmd        (cmd)
    );

    eno2pl_dp u_dp (
        .aclk        (aclk),
        .cmd         (cmd),
        .s_tdata     (s_tdata),
        .pts         (pts_reg),
        .eps         (eps_reg),
        .status      (status),
        .m_data      (m_tdata),
        .div_aresetn (aresetn)
    );

endmodule
